// ----- rtl/iir_direct_form_one_filter_macros.svh -----
// Assertion macros for the direct form I IIR filter.
// Used by the top level; expects clk and rst_n in the including scope.
`ifndef IIR_DIRECT_FORM_ONE_FILTER_MACROS_SVH
`define IIR_DIRECT_FORM_ONE_FILTER_MACROS_SVH

// Same-cycle implication, off during reset
`define IIRDF1_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off during reset
`define IIRDF1_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/iirdf1_pkg.sv -----
// Shared types and constants of the direct form I IIR filter.
// No dependencies; imported by every module of the block.
package iirdf1_pkg;

  // Fixed-point layout
  localparam int ACC_W         = 64;
  localparam int HIST_EXTRA    = 16;
  localparam int COEF_INT_BITS = 8;

  // Order register
  localparam int                ORDER_W     = 4;
  localparam logic [ORDER_W-1:0] ORDER_RESET = 4'd2;

  // Command queue between front and back end
  localparam int Q_DEPTH = 2;

  // Operation codes of an input beat
  typedef enum logic [1:0] {
    OP_FILTER = 2'd0,
    OP_COEF   = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  // Decoded command handed to the back end
  typedef enum logic [1:0] {
    CMD_FILTER,
    CMD_COEF_B,
    CMD_COEF_A,
    CMD_CLEAR
  } cmd_kind_t;

  // Back-end sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_WAIT,
    ST_ROUND,
    ST_OUT
  } eng_state_t;

endpackage

// ----- rtl/iirdf1_front.sv -----
// Front end of the IIR filter: accepts input beats and decodes them into commands.
// Depends on iirdf1_pkg; feeds iirdf1_queue.
module iirdf1_front
  import iirdf1_pkg::*;
#(
  parameter int MAX_ORDER = 8
) (
  input  logic                                   in_valid,
  input  logic [1:0]                             in_operation,
  input  logic [$clog2(MAX_ORDER+1):0]           in_coef_index,
  input  logic                                   q_full,
  output logic                                   stall,
  output logic                                   push,
  output cmd_kind_t                              kind,
  output logic [$clog2(MAX_ORDER+1)-1:0]         addr
);

  localparam int TAP_W  = $clog2(MAX_ORDER + 1);
  localparam int STEP_W = TAP_W + 1;

  logic keep;

  // Classify the beat; drop unknown operations and out-of-range indexes
  always_comb begin
    keep = 1'b0;
    kind = CMD_FILTER;
    addr = '0;
    unique case (op_t'(in_operation))
      OP_FILTER: begin
        keep = 1'b1;
        kind = CMD_FILTER;
      end
      OP_COEF: begin
        if (in_coef_index <= STEP_W'(MAX_ORDER)) begin
          keep = 1'b1;
          kind = CMD_COEF_B;
          addr = in_coef_index[TAP_W-1:0];
        end else if (in_coef_index <= STEP_W'(2 * MAX_ORDER)) begin
          keep = 1'b1;
          kind = CMD_COEF_A;
          addr = TAP_W'(in_coef_index - STEP_W'(MAX_ORDER + 1));
        end
      end
      OP_CLEAR: begin
        keep = 1'b1;
        kind = CMD_CLEAR;
      end
      OP_NONE: begin
        keep = 1'b0;
      end
    endcase
  end

  // Hold the input side while the queue is full
  assign stall = q_full;
  assign push  = in_valid && !q_full && keep;

endmodule

// ----- rtl/iirdf1_queue.sv -----
// Two-entry command queue between the front end and the filter engine.
// Depends on iirdf1_pkg for the command kind and queue depth.
module iirdf1_queue
  import iirdf1_pkg::*;
#(
  parameter int DATA_W = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  cmd_kind_t         push_kind,
  input  logic [DATA_W-1:0] push_data,
  input  logic              pop,
  output logic              full,
  output logic              valid,
  output cmd_kind_t         head_kind,
  output logic [DATA_W-1:0] head_data
);

  localparam int PTR_W = $clog2(Q_DEPTH);
  localparam int CNT_W = $clog2(Q_DEPTH + 1);

  cmd_kind_t         kind_mem_r [Q_DEPTH];
  logic [DATA_W-1:0] data_mem_r [Q_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;

  assign full      = (count_r == CNT_W'(Q_DEPTH));
  assign valid     = (count_r != '0);
  assign head_kind = kind_mem_r[rd_ptr_r];
  assign head_data = data_mem_r[rd_ptr_r];

  // Advance pointers and fill count
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + PTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + PTR_W'(1) : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store the pushed command
  always_ff @(posedge clk) begin
    if (push) begin
      kind_mem_r[wr_ptr_r] <= push_kind;
      data_mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ----- rtl/iirdf1_engine.sv -----
// Back end of the IIR filter: coefficient store, sample histories and the
// shared multiply-accumulate sequencer with rounding and output register.
// Depends on iirdf1_pkg; fed by iirdf1_queue.
module iirdf1_engine
  import iirdf1_pkg::*;
#(
  parameter int MAX_ORDER   = 8,
  parameter int SAMPLE_BITS = 16,
  parameter int COEF_BITS   = 32
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic [$clog2(MAX_ORDER+1)-1:0]       ord_lim,
  input  logic                                 q_valid,
  input  cmd_kind_t                            q_kind,
  input  logic signed [SAMPLE_BITS-1:0]        q_x,
  input  logic [$clog2(MAX_ORDER+1)-1:0]       q_addr,
  input  logic signed [COEF_BITS-1:0]          q_value,
  output logic                                 q_pop,
  input  logic                                 out_stall,
  output logic                                 out_valid,
  output logic signed [SAMPLE_BITS-1:0]        out_sample,
  output logic                                 out_sat
);

  localparam int TAP_W     = $clog2(MAX_ORDER + 1);
  localparam int STEP_W    = TAP_W + 1;
  localparam int HIST_IW   = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
  localparam int HIST_BITS = SAMPLE_BITS + HIST_EXTRA;
  localparam int PW        = COEF_BITS + HIST_BITS;
  localparam int SH_O      = COEF_BITS - COEF_INT_BITS;
  localparam int SH_H      = SH_O - HIST_EXTRA;

  localparam logic signed [ACC_W-1:0] OUT_HI  = (64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1;
  localparam logic signed [ACC_W-1:0] OUT_LO  = -OUT_HI - 64'sd1;
  localparam logic signed [ACC_W-1:0] HIST_HI = (64'sd1 <<< (HIST_BITS - 1)) - 64'sd1;
  localparam logic signed [ACC_W-1:0] HIST_LO = -HIST_HI - 64'sd1;
  localparam logic signed [ACC_W-1:0] RND_O   = 64'sd1 <<< (SH_O - 1);

  // Sequencer
  eng_state_t state_r, state_nxt;
  logic       issue, start, load_out;

  // Stores
  logic signed [COEF_BITS-1:0]   coef_b_r [MAX_ORDER+1];
  logic signed [COEF_BITS-1:0]   coef_a_r [MAX_ORDER];
  logic signed [SAMPLE_BITS-1:0] xh_r     [MAX_ORDER];
  logic signed [HIST_BITS-1:0]   yh_r     [MAX_ORDER];

  // Tap walk
  logic signed [SAMPLE_BITS-1:0] x_r;
  logic [STEP_W-1:0]             step_r, step_p1, last_step;
  logic [TAP_W-1:0]              tap;
  logic [HIST_IW-1:0]            hidx;
  logic                          fb;
  logic signed [COEF_BITS-1:0]   c_sel;
  logic signed [HIST_BITS-1:0]   d_sel;

  // MAC pipeline
  logic signed [COEF_BITS-1:0] op_c_r;
  logic signed [HIST_BITS-1:0] op_d_r;
  logic                        op_v_r, op_fb_r, op_last_r;
  logic signed [PW-1:0]        prod_r;
  logic                        pv_r, pfb_r, plast_r;
  logic signed [ACC_W-1:0]     prod_ext, fb_term;
  logic signed [ACC_W-1:0]     acc_r;
  logic                        acc_done_r;

  // Rounding
  logic signed [ACC_W-1:0]       t_o, yo_full, yh_full;
  logic signed [SAMPLE_BITS-1:0] yo;
  logic                          yo_sat;
  logic signed [HIST_BITS-1:0]   yh;
  logic signed [SAMPLE_BITS-1:0] yo_r;
  logic                          sat_r;
  logic signed [HIST_BITS-1:0]   yhn_r;

  // Output register
  logic                          out_valid_r;
  logic signed [SAMPLE_BITS-1:0] out_sample_r;
  logic                          out_sat_r;

  // Sequence one command at a time
  always_comb begin
    state_nxt = state_r;
    q_pop     = 1'b0;
    issue     = 1'b0;
    start     = 1'b0;
    load_out  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          if (q_kind == CMD_FILTER) begin
            start     = 1'b1;
            state_nxt = ST_ISSUE;
          end
        end
      end
      ST_ISSUE: begin
        issue = 1'b1;
        if (step_r == last_step) begin
          state_nxt = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (acc_done_r) begin
          state_nxt = ST_ROUND;
        end
      end
      ST_ROUND: begin
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid_r || !out_stall) begin
          load_out  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Write coefficients, clear or shift histories
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i <= MAX_ORDER; i++) begin
        coef_b_r[i] <= '0;
      end
      for (int i = 0; i < MAX_ORDER; i++) begin
        coef_a_r[i] <= '0;
        xh_r[i]     <= '0;
        yh_r[i]     <= '0;
      end
    end else begin
      if (q_pop) begin
        case (q_kind)
          CMD_COEF_B: coef_b_r[q_addr] <= q_value;
          CMD_COEF_A: coef_a_r[q_addr[HIST_IW-1:0]] <= q_value;
          CMD_CLEAR: begin
            for (int i = 0; i < MAX_ORDER; i++) begin
              xh_r[i] <= '0;
              yh_r[i] <= '0;
            end
          end
          default: begin
          end
        endcase
      end
      if (load_out) begin
        for (int i = MAX_ORDER - 1; i > 0; i--) begin
          xh_r[i] <= xh_r[i-1];
          yh_r[i] <= yh_r[i-1];
        end
        xh_r[0] <= x_r;
        yh_r[0] <= yhn_r;
      end
    end
  end

  // Pick the operands of this step: b0*x, then b[k]*x[n-k] and a[k]*y[n-k]
  always_comb begin
    step_p1   = step_r + STEP_W'(1);
    tap       = step_p1[STEP_W-1:1];
    hidx      = HIST_IW'(tap - TAP_W'(1));
    fb        = (step_r != '0) && !step_r[0];
    last_step = {ord_lim, 1'b0};
    c_sel     = fb ? coef_a_r[hidx] : coef_b_r[tap];
    if (step_r == '0) begin
      d_sel = HIST_BITS'(x_r);
    end else if (fb) begin
      d_sel = yh_r[hidx];
    end else begin
      d_sel = HIST_BITS'(xh_r[hidx]);
    end
  end

  // Issue stage and sample latch
  always_ff @(posedge clk) begin
    if (start) begin
      x_r    <= q_x;
      step_r <= '0;
    end else if (issue) begin
      step_r <= step_p1;
    end
    if (issue) begin
      op_c_r    <= c_sel;
      op_d_r    <= d_sel;
      op_fb_r   <= fb;
      op_last_r <= (step_r == last_step);
    end
    prod_r  <= op_c_r * op_d_r;
    pfb_r   <= op_fb_r;
    plast_r <= op_last_r;
  end

  // Feedback products drop their extra fraction bits before accumulation
  assign prod_ext = ACC_W'(prod_r);
  assign fb_term  = prod_ext >>> HIST_EXTRA;

  always_ff @(posedge clk) begin
    if (start) begin
      acc_r <= '0;
    end else if (pv_r) begin
      acc_r <= pfb_r ? acc_r - fb_term : acc_r + prod_ext;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op_v_r     <= 1'b0;
      pv_r       <= 1'b0;
      acc_done_r <= 1'b0;
    end else begin
      op_v_r     <= issue;
      pv_r       <= op_v_r;
      acc_done_r <= pv_r && plast_r;
    end
  end

  // Round half up and saturate the output sample
  always_comb begin
    t_o     = acc_r + RND_O;
    yo_full = t_o >>> SH_O;
    yo_sat  = (yo_full > OUT_HI) || (yo_full < OUT_LO);
    if (yo_full > OUT_HI) begin
      yo = OUT_HI[SAMPLE_BITS-1:0];
    end else if (yo_full < OUT_LO) begin
      yo = OUT_LO[SAMPLE_BITS-1:0];
    end else begin
      yo = yo_full[SAMPLE_BITS-1:0];
    end
  end

  // Scale the history entry to its wider fraction
  generate
    if (SH_H > 0) begin : g_hist_round
      assign yh_full = (acc_r + (64'sd1 <<< (SH_H - 1))) >>> SH_H;
    end else if (SH_H == 0) begin : g_hist_same
      assign yh_full = acc_r;
    end else begin : g_hist_widen
      assign yh_full = acc_r <<< (-SH_H);
    end
  endgenerate

  always_comb begin
    if (yh_full > HIST_HI) begin
      yh = HIST_HI[HIST_BITS-1:0];
    end else if (yh_full < HIST_LO) begin
      yh = HIST_LO[HIST_BITS-1:0];
    end else begin
      yh = yh_full[HIST_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_ROUND) begin
      yo_r  <= yo;
      sat_r <= yo_sat;
      yhn_r <= yh;
    end
  end

  // Output register: load a result, drop the valid once the beat is taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_sample_r <= yo_r;
      out_sat_r    <= sat_r;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_sample = out_sample_r;
  assign out_sat    = out_sat_r;

endmodule

// ----- rtl/iir_direct_form_one_filter.sv -----
// Direct form I IIR filter, y = sum b[k]x[n-k] - sum a[k]y[n-k], order N set by the
// order register (limited to MAX_ORDER). Operation 0 filters a Q1.15 sample and
// gives one result; operation 1 loads coefficient b0..bMAX (index 0..MAX_ORDER) or
// a1..aMAX (index MAX_ORDER+1..2*MAX_ORDER) in Q8.24; operation 2 clears both
// histories; loads, clears and other codes give no result. Input beats enter a
// two-entry command queue, so the input side takes up to two more commands while
// the filter runs or a result waits, and stalls once the queue is full.
// A filter sample holds the back end from taking the command in the idle state,
// through one tap product per cycle from the shared multiplier (2*N+1 products),
// the multiply/accumulate drain through the operand, product and accumulator
// registers and a rounding state, to an output load that waits while an earlier
// result is stalled. Loads and clears apply when taken. Results come out in order.
// Depends on iirdf1_pkg, iirdf1_front, iirdf1_queue, iirdf1_engine and the
// assertion macro header.
`include "iir_direct_form_one_filter_macros.svh"

module iir_direct_form_one_filter
  import iirdf1_pkg::*;
#(
  parameter int MAX_ORDER   = 8,
  parameter int SAMPLE_BITS = 16,
  parameter int COEF_BITS   = 32
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // Configuration
  input  logic                               cfg_we,
  input  logic [ORDER_W-1:0]                 cfg_wdata,
  // Input channel
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [1:0]                         in_operation,
  input  logic signed [SAMPLE_BITS-1:0]      in_sample_in,
  input  logic [$clog2(MAX_ORDER+1):0]       in_coef_index,
  input  logic signed [COEF_BITS-1:0]        in_coef_value,
  // Result channel
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [SAMPLE_BITS-1:0]      out_sample_out,
  output logic                               out_saturated
);

  localparam int TAP_W  = $clog2(MAX_ORDER + 1);
  localparam int DATA_W = SAMPLE_BITS + TAP_W + COEF_BITS;

  logic [ORDER_W-1:0] cfg_order_r;
  logic [TAP_W-1:0]   ord_lim;

  logic               push, q_full, q_valid, q_pop;
  cmd_kind_t          push_kind, q_kind;
  logic [TAP_W-1:0]   push_addr;
  logic [DATA_W-1:0]  push_data, q_data;

  logic signed [SAMPLE_BITS-1:0] q_x;
  logic [TAP_W-1:0]              q_addr;
  logic signed [COEF_BITS-1:0]   q_value;

  logic                          pop_other;

  // Order register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_order_r <= ORDER_RESET;
    end else if (cfg_we) begin
      cfg_order_r <= cfg_wdata;
    end
  end

  // Limit the order to the built depth
  always_comb begin
    if ({1'b0, cfg_order_r} > (ORDER_W + 1)'(MAX_ORDER)) begin
      ord_lim = TAP_W'(MAX_ORDER);
    end else begin
      ord_lim = TAP_W'(cfg_order_r);
    end
  end

  iirdf1_front #(
    .MAX_ORDER (MAX_ORDER)
  ) u_front (
    .in_valid      (in_valid),
    .in_operation  (in_operation),
    .in_coef_index (in_coef_index),
    .q_full        (q_full),
    .stall         (in_stall),
    .push          (push),
    .kind          (push_kind),
    .addr          (push_addr)
  );

  assign push_data = {in_sample_in, push_addr, in_coef_value};

  iirdf1_queue #(
    .DATA_W (DATA_W)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_kind (push_kind),
    .push_data (push_data),
    .pop       (q_pop),
    .full      (q_full),
    .valid     (q_valid),
    .head_kind (q_kind),
    .head_data (q_data)
  );

  assign q_x     = q_data[DATA_W-1 -: SAMPLE_BITS];
  assign q_addr  = q_data[COEF_BITS +: TAP_W];
  assign q_value = q_data[COEF_BITS-1:0];

  iirdf1_engine #(
    .MAX_ORDER   (MAX_ORDER),
    .SAMPLE_BITS (SAMPLE_BITS),
    .COEF_BITS   (COEF_BITS)
  ) u_engine (
    .clk        (clk),
    .rst_n      (rst_n),
    .ord_lim    (ord_lim),
    .q_valid    (q_valid),
    .q_kind     (q_kind),
    .q_x        (q_x),
    .q_addr     (q_addr),
    .q_value    (q_value),
    .q_pop      (q_pop),
    .out_stall  (out_stall),
    .out_valid  (out_valid),
    .out_sample (out_sample_out),
    .out_sat    (out_saturated)
  );

  // A command taken that is not a filter sample
  assign pop_other = q_pop && (q_kind != CMD_FILTER);

  // The engine only takes a command that the queue holds
  `IIRDF1_ASSERT_SAME(a_pop_has_cmd, q_pop, q_valid, "pop from empty command queue")

  // Coefficient loads and clears never produce a result
  `IIRDF1_ASSERT_NEXT(a_no_result_on_load, pop_other, !$rose(out_valid), "load gave a result")

  // A result is never loaded in the cycle right after a command is taken
  `IIRDF1_ASSERT_SAME(a_result_not_after_pop, $rose(out_valid), !$past(q_pop), "early result")

endmodule

// ----- tb/tb_iir_direct_form_one_filter.sv -----
// Testbench for the direct form I IIR filter: directed table, then random phases
// checked against a fixed-point predictor kept in lockstep. Needs iirdf1_pkg and the RTL.
module tb_iir_direct_form_one_filter;
  import iirdf1_pkg::*;

  localparam int MAX_ORDER       = 8;
  localparam int COEF_FRAC       = 24;
  localparam int IDX_B0          = 0;
  localparam int IDX_B_LAST      = MAX_ORDER;
  localparam int IDX_A1          = MAX_ORDER + 1;
  localparam int IDX_A_LAST      = 2 * MAX_ORDER;
  localparam int SETTLE_CYCLES   = 60;
  localparam int CYCLE_LIMIT     = 400000;
  localparam int NUM_PHASES      = 6;
  localparam int ITEMS_PER_PHASE = 125;
  localparam int MAX_REPORTS     = 10;

  typedef struct {
    logic signed [15:0] sample;
    logic               sat;
  } filt_result_t;

  typedef struct {
    op_t                op;
    logic signed [15:0] sample;
    logic [4:0]         idx;
    logic signed [31:0] value;
    bit                 lit;
    logic signed [15:0] lit_sample;
    logic               lit_sat;
  } stim_row_t;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               cfg_we;
  logic [3:0]         cfg_wdata;
  logic               in_valid;
  logic               in_stall;
  logic [1:0]         in_operation;
  logic signed [15:0] in_sample_in;
  logic [4:0]         in_coef_index;
  logic signed [31:0] in_coef_value;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [15:0] out_sample_out;
  logic               out_saturated;

  // Literal expectation travels with the beat it belongs to
  logic               beat_lit;
  logic signed [15:0] beat_lit_sample;
  logic               beat_lit_sat;

  // Predictor state
  logic [3:0] order_reg;
  longint     b_coef [0:MAX_ORDER];
  longint     a_coef [0:MAX_ORDER];
  longint     x_hist [0:MAX_ORDER-1];
  longint     y_hist [0:MAX_ORDER-1];

  filt_result_t expected_samples [$];

  int idle_pct  = 0;
  int stall_pct = 0;
  int cycles    = 0;
  int mismatches = 0;
  int n_filtered = 0;
  int n_loads    = 0;
  int n_clears   = 0;
  int n_checked  = 0;

  iir_direct_form_one_filter i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_operation  (in_operation),
    .in_sample_in  (in_sample_in),
    .in_coef_index (in_coef_index),
    .in_coef_value (in_coef_value),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_sample_out(out_sample_out),
    .out_saturated (out_saturated)
  );

  always #1 clk = ~clk;

  // Run one sample through the predicted filter and advance its histories
  task automatic filter_predict(input logic signed [15:0] x_in, output filt_result_t res);
    longint acc;
    longint x;
    longint yo;
    longint yn;
    int     n;
    x   = x_in;
    n   = (order_reg > MAX_ORDER) ? MAX_ORDER : int'(order_reg);
    acc = b_coef[0] * x;
    for (int k = 1; k <= n; k++) begin
      acc = acc + b_coef[k] * x_hist[k-1];
      acc = acc - ((a_coef[k] * y_hist[k-1]) >>> HIST_EXTRA);
    end
    yo = (acc + (longint'(1) << (COEF_FRAC - 1))) >>> COEF_FRAC;
    res.sat = 1'b0;
    if (yo > 32767) begin
      yo = 32767;
      res.sat = 1'b1;
    end else if (yo < -32768) begin
      yo = -32768;
      res.sat = 1'b1;
    end
    res.sample = yo[15:0];
    yn = (acc + (longint'(1) << (COEF_FRAC - HIST_EXTRA - 1))) >>> (COEF_FRAC - HIST_EXTRA);
    if (yn > 64'sd2147483647) yn = 64'sd2147483647;
    else if (yn < -64'sd2147483648) yn = -64'sd2147483648;
    for (int k = MAX_ORDER - 1; k > 0; k--) begin
      x_hist[k] = x_hist[k-1];
      y_hist[k] = y_hist[k-1];
    end
    x_hist[0] = x;
    y_hist[0] = yn;
  endtask

  // Track accepted beats and check every delivered result
  always @(posedge clk) begin
    filt_result_t r;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still pending", cycles,
               expected_samples.size());
      $display("tb_iir_direct_form_one_filter failed");
      $finish;
    end
    if (!rst_n) begin
      order_reg = ORDER_RESET;
      for (int k = 0; k <= MAX_ORDER; k++) begin
        b_coef[k] = 0;
        a_coef[k] = 0;
      end
      for (int k = 0; k < MAX_ORDER; k++) begin
        x_hist[k] = 0;
        y_hist[k] = 0;
      end
    end else begin
      if (cfg_we) order_reg = cfg_wdata;
      if (in_valid && !in_stall) begin
        case (op_t'(in_operation))
          OP_FILTER: begin
            filter_predict(in_sample_in, r);
            if (beat_lit) begin
              r.sample = beat_lit_sample;
              r.sat    = beat_lit_sat;
            end
            expected_samples.push_back(r);
            n_filtered++;
          end
          OP_COEF: begin
            n_loads++;
            if (in_coef_index <= IDX_B_LAST) b_coef[in_coef_index] = longint'(in_coef_value);
            else if (in_coef_index <= IDX_A_LAST)
              a_coef[in_coef_index - MAX_ORDER] = longint'(in_coef_value);
          end
          OP_CLEAR: begin
            n_clears++;
            for (int k = 0; k < MAX_ORDER; k++) begin
              x_hist[k] = 0;
              y_hist[k] = 0;
            end
          end
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (expected_samples.size() == 0) begin
          if (mismatches < MAX_REPORTS)
            $display("unexpected result: sample %0d sat %0b", out_sample_out, out_saturated);
          mismatches++;
        end else begin
          r = expected_samples.pop_front();
          n_checked++;
          if (out_sample_out !== r.sample || out_saturated !== r.sat) begin
            if (mismatches < MAX_REPORTS)
              $display("mismatch at cycle %0d: sample exp %0d got %0d, sat exp %0b got %0b",
                       cycles, r.sample, out_sample_out, r.sat, out_saturated);
            mismatches++;
          end
        end
      end
    end
  end

  // Receiver back-pressure
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  function automatic stim_row_t mk_row(op_t op, int sample, int idx, logic [31:0] value,
                                       bit lit, int lit_sample, bit lit_sat);
    stim_row_t row;
    row.op         = op;
    row.sample     = 16'(sample);
    row.idx        = 5'(idx);
    row.value      = value;
    row.lit        = lit;
    row.lit_sample = 16'(lit_sample);
    row.lit_sat    = lit_sat;
    return row;
  endfunction

  function automatic stim_row_t random_row();
    stim_row_t row;
    int        pick;
    row  = mk_row(OP_FILTER, 0, 0, 32'd0, 1'b0, 0, 1'b0);
    pick = $urandom_range(99);
    if (pick < 70) row.op = OP_FILTER;
    else if (pick < 88) row.op = OP_COEF;
    else if (pick < 94) row.op = OP_CLEAR;
    else row.op = OP_NONE;
    case ($urandom_range(9))
      0:       row.sample = 16'sh7fff;
      1:       row.sample = -16'sh8000;
      default: row.sample = 16'($urandom());
    endcase
    if ($urandom_range(9) == 0) row.idx = 5'($urandom_range(IDX_A_LAST + 1, 31));
    else row.idx = 5'($urandom_range(IDX_B0, IDX_A_LAST));
    // Mostly modest coefficients keep the filter in range; some are raw words
    if ($urandom_range(7) == 0) row.value = $urandom();
    else row.value = $signed($urandom_range(0, 1 << 24)) - (1 << 23);
    return row;
  endfunction

  // Present one beat and hold it until accepted
  task automatic send_beat(input stim_row_t row);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid        <= 1'b1;
    in_operation    <= row.op;
    in_sample_in    <= row.sample;
    in_coef_index   <= row.idx;
    in_coef_value   <= row.value;
    beat_lit        <= row.lit;
    beat_lit_sample <= row.lit_sample;
    beat_lit_sat    <= row.lit_sat;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Drop valid, drain all results, then let queued loads and clears finish
  task automatic settle_block();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_samples.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  initial begin
    stim_row_t  directed [$];
    logic [3:0] phase_order;
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_wdata       = '0;
    in_valid        = 1'b0;
    in_operation    = OP_NONE;
    in_sample_in    = '0;
    in_coef_index   = '0;
    in_coef_value   = '0;
    beat_lit        = 1'b0;
    beat_lit_sample = '0;
    beat_lit_sat    = 1'b0;

    // Zero coefficients after reset, then b0 at unity and both extremes
    directed.push_back(mk_row(OP_FILTER, 0, 0, 32'd0, 1, 0, 0));
    directed.push_back(mk_row(OP_FILTER, 32767, 0, 32'd0, 1, 0, 0));
    directed.push_back(mk_row(OP_COEF, 0, IDX_B0, 32'h0100_0000, 0, 0, 0));
    directed.push_back(mk_row(OP_FILTER, 32767, 0, 32'd0, 1, 32767, 0));
    directed.push_back(mk_row(OP_FILTER, -32768, 0, 32'd0, 1, -32768, 0));
    directed.push_back(mk_row(OP_COEF, 0, IDX_B0, 32'h7fff_ffff, 0, 0, 0));
    directed.push_back(mk_row(OP_FILTER, 32767, 0, 32'd0, 1, 32767, 1));
    directed.push_back(mk_row(OP_FILTER, -32768, 0, 32'd0, 1, -32768, 1));
    directed.push_back(mk_row(OP_COEF, 0, IDX_B0, 32'h8000_0000, 0, 0, 0));
    directed.push_back(mk_row(OP_FILTER, 1, 0, 32'd0, 1, -128, 0));
    // Feedforward and feedback taps, last taps, indexes past the store
    directed.push_back(mk_row(OP_COEF, 0, IDX_B0 + 1, 32'h0080_0000, 0, 0, 0));
    directed.push_back(mk_row(OP_COEF, 0, IDX_A1, 32'hff40_0000, 0, 0, 0));
    directed.push_back(mk_row(OP_COEF, 0, IDX_A_LAST, 32'h7fff_ffff, 0, 0, 0));
    directed.push_back(mk_row(OP_COEF, 0, IDX_A_LAST + 1, 32'h1234_5678, 0, 0, 0));
    directed.push_back(mk_row(OP_COEF, 0, 31, 32'hffff_ffff, 0, 0, 0));
    directed.push_back(mk_row(OP_FILTER, 12345, 0, 32'd0, 0, 0, 0));
    directed.push_back(mk_row(OP_FILTER, -1, 0, 32'd0, 0, 0, 0));
    directed.push_back(mk_row(OP_NONE, 555, 3, 32'h0, 0, 0, 0));
    directed.push_back(mk_row(OP_FILTER, 100, 0, 32'd0, 0, 0, 0));
    directed.push_back(mk_row(OP_CLEAR, 0, 0, 32'd0, 0, 0, 0));
    directed.push_back(mk_row(OP_FILTER, 32767, 0, 32'd0, 0, 0, 0));
    directed.push_back(mk_row(OP_COEF, 0, IDX_B_LAST, 32'h0040_0000, 0, 0, 0));
    directed.push_back(mk_row(OP_FILTER, -20000, 0, 32'd0, 0, 0, 0));

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed table at the reset order with light idling
    idle_pct  = 20;
    stall_pct = 20;
    foreach (directed[i]) send_beat(directed[i]);

    // Random phases, each under its own order and idling mix
    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0:       phase_order = 4'd1;
        1:       phase_order = 4'd8;
        2:       phase_order = 4'd0;
        3:       phase_order = 4'd15;
        4:       phase_order = 4'd3;
        default: phase_order = 4'($urandom_range(1, MAX_ORDER));
      endcase
      settle_block();
      cfg_we    <= 1'b1;
      cfg_wdata <= phase_order;
      @(negedge clk);
      cfg_we <= 1'b0;
      case (p % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 62; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 62; end
        default: begin idle_pct = 20; stall_pct = 20; end
      endcase
      for (int i = 0; i < ITEMS_PER_PHASE; i++) send_beat(random_row());
    end

    settle_block();
    $display("covered %0d samples, %0d coefficient loads, %0d clears", n_filtered, n_loads,
             n_clears);
    $display("orders 0, 1, 2, 3, 8, 15 and one random; %0d results checked, %0d mismatches",
             n_checked, mismatches);
    if (mismatches == 0 && expected_samples.size() == 0) begin
      $display("tb_iir_direct_form_one_filter passed");
    end else begin
      $display("tb_iir_direct_form_one_filter failed");
    end
    $finish;
  end

endmodule
